/* hw/rtl/apa_pkg.sv */
// apa_pkg: shared types and constants for the animation playhead advance block.
// Depends on nothing; used by apa_divider, animation_playhead_advance, the checker and the bench.
package apa_pkg;

    localparam int TIME_FRAC_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int DUR_W      = 32;
    localparam int DT_W       = 16;
    localparam int RATE_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PLAY_ENABLE    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MODE       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_DURATION = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_RATE      = 4'd3;

    localparam logic [1:0] MODE_CLAMP    = 2'd0;
    localparam logic [1:0] MODE_LOOP     = 2'd1;
    localparam logic [1:0] MODE_PINGPONG = 2'd2;

    localparam logic [DUR_W-1:0]  DUR_RESET  = 32'h0001_0000;
    localparam logic [RATE_W-1:0] RATE_RESET = 16'h0100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_CHK,
        ST_DIV,
        ST_DONE
    } apa_state_t;

    typedef struct packed {
        logic done;
        logic q_odd;
    } apa_div_status_t;

endpackage

/* hw/rtl/apa_divider.sv */
// apa_divider: radix-2 restoring divider, one quotient bit per cycle.
// Returns the remainder and the quotient parity. Depends on apa_pkg.
module apa_divider #(
    parameter int QW = 33
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [QW-1:0]                dividend,
    input  logic [apa_pkg::DUR_W-1:0]    divisor,
    output apa_pkg::apa_div_status_t     status,
    output logic [apa_pkg::DUR_W-1:0]    remainder
);

    localparam int CNT_W = $clog2(QW + 1);

    logic [QW-1:0]             dvd_reg;
    logic [apa_pkg::DUR_W-1:0] dsr_reg;
    logic [apa_pkg::DUR_W-1:0] rem_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic                      qlsb_reg;

    logic [apa_pkg::DUR_W:0]   trial;
    logic                      fits;
    logic [apa_pkg::DUR_W:0]   diff;

    assign trial = {rem_reg, dvd_reg[QW-1]};
    assign fits  = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg  <= dividend;
            dsr_reg  <= divisor;
            rem_reg  <= '0;
            qlsb_reg <= 1'b0;
        end else if (busy_reg) begin
            dvd_reg  <= {dvd_reg[QW-2:0], 1'b0};
            rem_reg  <= fits ? diff[apa_pkg::DUR_W-1:0] : trial[apa_pkg::DUR_W-1:0];
            qlsb_reg <= fits;
        end
    end

    assign status.done  = done_reg;
    assign status.q_odd = qlsb_reg;
    assign remainder    = rem_reg;

endmodule

/* hw/rtl/animation_playhead_advance.sv */
// animation_playhead_advance: top level, sequencer and datapath of the playhead.
// Depends on apa_pkg and apa_divider.
//
// Usage:
//  - Config port: cfg_wr_en/cfg_index/cfg_data, no read-back.
//    Index 0 play_enable, 1 end_mode, 2 track_duration, 3 base_rate; others ignored.
//    Write only while the block is idle.
//  - Input channel s_valid/s_ready carries one tick (s_delta_time) per transfer.
//  - Result channel m_valid/m_ready carries exactly one result per tick.
//  - A tick that moves the playhead off the track in loop or ping-pong mode
//    goes through multiply, add and check and then the bit-serial divider
//    (one quotient bit per cycle, QW dividend bits) before done. Other ticks
//    skip the divider; disabled or halted ticks go straight to done.
//  - One tick at a time: s_ready is high only while the sequencer is idle, so a
//    new tick is not taken before the last one has left the done state.
//  - A finished result sits in an output register; the next tick is accepted
//    while it waits. If the receiver stalls, the following result holds in
//    the done state until the output register frees up.
//  - Reset (aresetn low, synchronous) clears playhead, direction, sticky flags
//    and loads register defaults (duration 1.0, rate 1.0, disabled, clamp).
module animation_playhead_advance #(
    parameter int TIME_FRAC_BITS = apa_pkg::TIME_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [apa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [apa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [apa_pkg::DT_W-1:0]          s_delta_time,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [apa_pkg::DUR_W-1:0]         m_position,
    output logic                              m_wrapped,
    output logic                              m_stopped,
    output logic                              m_reversed,
    output logic                              m_updated
);

    // product of Q4.12 time and signed Q8.8 rate (17 bits after negation): Q.20
    localparam int PROD_W = apa_pkg::DT_W + apa_pkg::RATE_W + 2;
    localparam int SH_R   = (TIME_FRAC_BITS < 20) ? 20 - TIME_FRAC_BITS : 0;
    localparam int SH_L   = (TIME_FRAC_BITS > 20) ? TIME_FRAC_BITS - 20 : 0;
    localparam int STEP_W = PROD_W - SH_R + SH_L;
    localparam int P_W    = ((STEP_W > apa_pkg::DUR_W + 1) ? STEP_W : apa_pkg::DUR_W + 1) + 1;
    localparam int QW     = P_W - 1;

    apa_pkg::apa_state_t state_reg, state_next;

    // configuration
    logic                        play_enable_reg;
    logic [1:0]                  end_mode_reg;
    logic [apa_pkg::DUR_W-1:0]   duration_reg;
    logic [apa_pkg::RATE_W-1:0]  base_rate_reg;

    // architectural state
    logic [apa_pkg::DUR_W-1:0]   playhead_reg, playhead_next;
    logic                        flip_reg, flip_next;
    logic                        wrap_reg, wrap_next;
    logic                        halted_reg, halted_next;
    logic                        upd_reg, upd_next;

    // working registers
    logic [apa_pkg::DT_W-1:0]    dt_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [P_W-1:0]       p_reg;
    logic                        neg_reg;
    logic                        qle_reg;
    logic [apa_pkg::DUR_W-1:0]   qlo_reg;

    // output register
    logic                        m_valid_reg;
    logic [apa_pkg::DUR_W-1:0]   m_position_reg;
    logic                        m_wrapped_reg;
    logic                        m_stopped_reg;
    logic                        m_reversed_reg;
    logic                        m_updated_reg;

    logic                        in_xfer;
    logic                        out_free;
    logic                        div_start;
    logic                        skip_tick;
    logic                        is_loop;
    logic                        is_pp;

    logic [apa_pkg::DUR_W-1:0]   dur_eff;
    logic signed [P_W-1:0]       dur_ext;
    logic signed [apa_pkg::RATE_W:0] rate_eff;
    logic signed [P_W-1:0]       prod_ext;
    logic signed [P_W-1:0]       step;
    logic signed [P_W-1:0]       p_sum;
    logic                        p_neg;
    logic                        p_over;
    logic [P_W-1:0]              q_full;
    logic [QW-1:0]               q_mag;

    apa_pkg::apa_div_status_t    div_status;
    logic [apa_pkg::DUR_W-1:0]   div_rem;
    logic                        rem_zero;
    logic [apa_pkg::DUR_W-1:0]   dur_minus_rem;

    assign in_xfer   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign skip_tick = !play_enable_reg || halted_reg;
    assign is_loop   = (end_mode_reg == apa_pkg::MODE_LOOP);
    assign is_pp     = (end_mode_reg == apa_pkg::MODE_PINGPONG);

    // zero duration acts as one LSB
    assign dur_eff = (duration_reg == '0) ? apa_pkg::DUR_W'(1) : duration_reg;
    assign dur_ext = $signed({{(P_W - apa_pkg::DUR_W){1'b0}}, dur_eff});

    // signed rate, negated while reversed
    assign rate_eff = flip_reg ? -$signed({base_rate_reg[apa_pkg::RATE_W-1], base_rate_reg})
                               :  $signed({base_rate_reg[apa_pkg::RATE_W-1], base_rate_reg});

    // Q.20 to Q.F: arithmetic right shift floors, left shift is exact
    assign prod_ext = P_W'(prod_reg);
    assign step     = (prod_ext >>> SH_R) <<< SH_L;
    assign p_sum    = $signed({{(P_W - apa_pkg::DUR_W){1'b0}}, playhead_reg}) + step;

    assign p_neg  = p_reg[P_W-1];
    assign p_over = !p_neg && (p_reg > dur_ext);
    assign q_full = p_neg ? P_W'(-p_reg) : P_W'(p_reg);
    assign q_mag  = q_full[QW-1:0];

    assign rem_zero      = (div_rem == '0);
    assign dur_minus_rem = dur_eff - div_rem;

    apa_divider #(
        .QW (QW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (q_mag),
        .divisor   (dur_eff),
        .status    (div_status),
        .remainder (div_rem)
    );

    // sequencer: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            apa_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    state_next = skip_tick ? apa_pkg::ST_DONE : apa_pkg::ST_MUL;
                end
            end
            apa_pkg::ST_MUL: state_next = apa_pkg::ST_ADD;
            apa_pkg::ST_ADD: state_next = apa_pkg::ST_CHK;
            apa_pkg::ST_CHK: begin
                if ((p_neg || p_over) && (is_loop || is_pp)) begin
                    state_next = apa_pkg::ST_DIV;
                end else begin
                    state_next = apa_pkg::ST_DONE;
                end
            end
            apa_pkg::ST_DIV: begin
                if (div_status.done) begin
                    state_next = apa_pkg::ST_DONE;
                end
            end
            apa_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = apa_pkg::ST_IDLE;
                end
            end
            default: state_next = apa_pkg::ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            apa_pkg::ST_IDLE: s_ready = 1'b1;
            apa_pkg::ST_CHK:  div_start = (p_neg || p_over) && (is_loop || is_pp);
            default: begin
                s_ready   = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    // playhead, update flag and end-of-track handling
    always_comb begin
        playhead_next = playhead_reg;
        flip_next     = flip_reg;
        wrap_next     = wrap_reg;
        halted_next   = halted_reg;
        upd_next      = upd_reg;
        case (state_reg)
            apa_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    upd_next = !skip_tick;
                end
            end
            apa_pkg::ST_CHK: begin
                if (p_neg || p_over) begin
                    wrap_next = 1'b1;
                    if (!(is_loop || is_pp)) begin
                        // clamp (and unused mode): pin to the crossed end, stop
                        halted_next   = 1'b1;
                        playhead_next = p_neg ? '0 : dur_eff;
                    end
                end else begin
                    playhead_next = p_reg[apa_pkg::DUR_W-1:0];
                end
            end
            apa_pkg::ST_DIV: begin
                if (div_status.done) begin
                    if (is_loop) begin
                        if (neg_reg) begin
                            playhead_next = rem_zero ? '0 : dur_minus_rem;
                        end else begin
                            playhead_next = rem_zero ? dur_eff : div_rem;
                        end
                    end else if (neg_reg) begin
                        if (qle_reg) begin
                            playhead_next = qlo_reg;
                            flip_next     = !flip_reg;
                        end else if (div_status.q_odd) begin
                            playhead_next = dur_minus_rem;
                        end else begin
                            playhead_next = div_rem;
                            flip_next     = !flip_reg;
                        end
                    end else begin
                        if (div_status.q_odd) begin
                            playhead_next = dur_minus_rem;
                            flip_next     = !flip_reg;
                        end else begin
                            playhead_next = div_rem;
                        end
                    end
                end
            end
            default: begin
                playhead_next = playhead_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= apa_pkg::ST_IDLE;
            play_enable_reg <= 1'b0;
            end_mode_reg    <= apa_pkg::MODE_CLAMP;
            duration_reg    <= apa_pkg::DUR_RESET;
            base_rate_reg   <= apa_pkg::RATE_RESET;
            playhead_reg    <= '0;
            flip_reg        <= 1'b0;
            wrap_reg        <= 1'b0;
            halted_reg      <= 1'b0;
            upd_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            playhead_reg <= playhead_next;
            flip_reg     <= flip_next;
            wrap_reg     <= wrap_next;
            halted_reg   <= halted_next;
            upd_reg      <= upd_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    apa_pkg::REG_PLAY_ENABLE:    play_enable_reg <= cfg_data[0];
                    apa_pkg::REG_END_MODE:       end_mode_reg    <= cfg_data[1:0];
                    apa_pkg::REG_TRACK_DURATION: duration_reg    <= cfg_data[apa_pkg::DUR_W-1:0];
                    apa_pkg::REG_BASE_RATE:      base_rate_reg   <= cfg_data[apa_pkg::RATE_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == apa_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            dt_reg <= s_delta_time;
        end
        if (state_reg == apa_pkg::ST_MUL) begin
            prod_reg <= $signed({1'b0, dt_reg}) * rate_eff;
        end
        if (state_reg == apa_pkg::ST_ADD) begin
            p_reg <= p_sum;
        end
        if (state_reg == apa_pkg::ST_CHK) begin
            neg_reg <= p_neg;
            qle_reg <= (q_mag <= QW'(dur_eff));
            qlo_reg <= q_mag[apa_pkg::DUR_W-1:0];
        end
        if (state_reg == apa_pkg::ST_DONE && out_free) begin
            m_position_reg <= playhead_reg;
            m_wrapped_reg  <= wrap_reg;
            m_stopped_reg  <= halted_reg;
            m_reversed_reg <= flip_reg;
            m_updated_reg  <= upd_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_position = m_position_reg;
    assign m_wrapped  = m_wrapped_reg;
    assign m_stopped  = m_stopped_reg;
    assign m_reversed = m_reversed_reg;
    assign m_updated  = m_updated_reg;

    // one tick in flight: no second transfer right after one
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_ready)
        else $error("input accepted while a tick is in progress");

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halted flag cleared");

    // halting only happens at a track end, so the wrap flag is set with it
    a_halt_implies_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> wrap_reg)
        else $error("halted without wrap flag");

    // divider result is used only while dividing
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.done |-> (state_reg == apa_pkg::ST_DIV))
        else $error("divider finished outside of divide state");

endmodule

/* dv/animation_playhead_advance_checker.sv */
// Scoreboard for animation_playhead_advance: tracks register writes, predicts one
// report per accepted tick and compares each result transfer field by field.
// Depends on apa_pkg.
`timescale 1ns / 1ps

module animation_playhead_advance_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [apa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [apa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [apa_pkg::DT_W-1:0]       s_delta_time,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [apa_pkg::DUR_W-1:0]      m_position,
    input  logic                           m_wrapped,
    input  logic                           m_stopped,
    input  logic                           m_reversed,
    input  logic                           m_updated,
    output int                             mismatch_count,
    output int                             reports_due
);

    // dt (12 frac) * rate (8 frac) carries 20 fraction bits
    localparam int STEP_SHIFT = 20 - apa_pkg::TIME_FRAC_BITS_DEF;

    typedef struct packed {
        logic [apa_pkg::DUR_W-1:0] position;
        logic                      wrapped;
        logic                      stopped;
        logic                      reversed;
        logic                      updated;
    } playhead_report_t;

    // register image
    logic                       cfg_running;
    logic [1:0]                 cfg_mode;
    logic [apa_pkg::DUR_W-1:0]  cfg_length;
    logic [apa_pkg::RATE_W-1:0] cfg_speed;

    // playhead state
    logic [apa_pkg::DUR_W-1:0]  head_pos;
    logic                       run_reversed;
    logic                       end_reached;
    logic                       frozen;

    playhead_report_t  predicted_reports[$];
    int                results_seen;

    function automatic playhead_report_t advance_playhead(
        input logic [apa_pkg::DT_W-1:0] dt);
        longint           speed, stride, pos, span;
        logic [63:0]      span_u, reach, laps, rest;
        playhead_report_t rep;
        rep.updated = 1'b0;
        if (cfg_running && !frozen) begin
            speed = longint'($signed(cfg_speed));
            if (run_reversed) begin
                speed = -speed;
            end
            span_u = (cfg_length == '0) ? 64'd1 : {32'd0, cfg_length};
            span   = longint'(span_u);
            // arithmetic shift floors negative steps
            stride = (longint'(dt) * speed) >>> STEP_SHIFT;
            pos    = longint'(head_pos) + stride;
            if (pos < 0) begin
                end_reached = 1'b1;
                reach = -pos;
                case (cfg_mode)
                    apa_pkg::MODE_LOOP: begin
                        rest = reach % span_u;
                        pos  = (rest == 0) ? 0 : longint'(span_u - rest);
                    end
                    apa_pkg::MODE_PINGPONG: begin
                        if (reach <= span_u) begin
                            pos          = longint'(reach);
                            run_reversed = !run_reversed;
                        end else begin
                            laps = reach / span_u;
                            rest = reach % span_u;
                            if (laps[0]) begin
                                pos = longint'(span_u - rest);
                            end else begin
                                pos          = longint'(rest);
                                run_reversed = !run_reversed;
                            end
                        end
                    end
                    default: begin  // clamp, spare code included
                        frozen = 1'b1;
                        pos    = 0;
                    end
                endcase
            end else if (pos > span) begin
                end_reached = 1'b1;
                reach = pos;
                case (cfg_mode)
                    apa_pkg::MODE_LOOP: begin
                        rest = reach % span_u;
                        pos  = (rest == 0) ? span : longint'(rest);
                    end
                    apa_pkg::MODE_PINGPONG: begin
                        laps = reach / span_u;
                        rest = reach % span_u;
                        if (laps[0]) begin
                            pos          = longint'(span_u - rest);
                            run_reversed = !run_reversed;
                        end else begin
                            pos = longint'(rest);
                        end
                    end
                    default: begin
                        frozen = 1'b1;
                        pos    = span;
                    end
                endcase
            end
            head_pos    = pos[apa_pkg::DUR_W-1:0];
            rep.updated = 1'b1;
        end
        rep.position = head_pos;
        rep.wrapped  = end_reached;
        rep.stopped  = frozen;
        rep.reversed = run_reversed;
        return rep;
    endfunction

    function automatic void check_field(input string what,
                                        input logic [apa_pkg::DUR_W-1:0] want,
                                        input logic [apa_pkg::DUR_W-1:0] got);
        if (got !== want) begin
            $display("[%0t] result %0d %s: expected 0x%0h, actual 0x%0h",
                     $time, results_seen, what, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        playhead_report_t want;
        if (!aresetn) begin
            cfg_running  = 1'b0;
            cfg_mode     = apa_pkg::MODE_CLAMP;
            cfg_length   = apa_pkg::DUR_RESET;
            cfg_speed    = apa_pkg::RATE_RESET;
            head_pos     = '0;
            run_reversed = 1'b0;
            end_reached  = 1'b0;
            frozen       = 1'b0;
            results_seen = 0;
            predicted_reports.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    apa_pkg::REG_PLAY_ENABLE:    cfg_running = cfg_data[0];
                    apa_pkg::REG_END_MODE:       cfg_mode    = cfg_data[1:0];
                    apa_pkg::REG_TRACK_DURATION: cfg_length  = cfg_data[apa_pkg::DUR_W-1:0];
                    apa_pkg::REG_BASE_RATE:      cfg_speed   = cfg_data[apa_pkg::RATE_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (predicted_reports.size() == 0) begin
                    $display("[%0t] result transfer with no tick outstanding, position 0x%0h",
                             $time, m_position);
                    mismatch_count++;
                end else begin
                    want = predicted_reports.pop_front();
                    check_field("position", want.position, m_position);
                    check_field("wrapped",  apa_pkg::DUR_W'(want.wrapped),
                                apa_pkg::DUR_W'(m_wrapped));
                    check_field("stopped",  apa_pkg::DUR_W'(want.stopped),
                                apa_pkg::DUR_W'(m_stopped));
                    check_field("reversed", apa_pkg::DUR_W'(want.reversed),
                                apa_pkg::DUR_W'(m_reversed));
                    check_field("updated",  apa_pkg::DUR_W'(want.updated),
                                apa_pkg::DUR_W'(m_updated));
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                predicted_reports.push_back(advance_playhead(s_delta_time));
            end
        end
        reports_due <= predicted_reports.size();
    end

endmodule

/* dv/animation_playhead_advance_tb.sv */
// Top of the animation_playhead_advance bench: clock, reset, register writes,
// tick stimulus and result back-pressure; checking lives in the checker module.
// Depends on apa_pkg, animation_playhead_advance and animation_playhead_advance_checker.
`timescale 1ns / 1ps

module animation_playhead_advance_tb;

    localparam int CLK_HALF      = 4;
    // the limit sits far above the longest quiet stretch of a correct run
    // (tick gap + divide path + result stall + a burst of register writes)
    localparam int QUIET_LIMIT   = 2000;
    // wait past the divide path for stray results
    localparam int SETTLE_CYCLES = 60;
    localparam int RANDOM_PHASES = 13;

    localparam int SIDE_TX = 0;
    localparam int SIDE_RX = 1;

    // codes the block must tolerate but that the package leaves unnamed
    localparam logic [apa_pkg::CFG_IDX_W-1:0] REG_NONE   = 4'd15;
    localparam logic [1:0]                    MODE_SPARE = 2'd3;

    logic                           aclk         = 1'b0;
    logic                           aresetn      = 1'b0;
    logic                           cfg_wr_en    = 1'b0;
    logic [apa_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [apa_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
    logic                           s_valid      = 1'b0;
    logic                           s_ready;
    logic [apa_pkg::DT_W-1:0]       s_delta_time = '0;
    logic                           m_valid;
    logic                           m_ready      = 1'b0;
    logic [apa_pkg::DUR_W-1:0]      m_position;
    logic                           m_wrapped;
    logic                           m_stopped;
    logic                           m_reversed;
    logic                           m_updated;

    int mismatch_count;
    int reports_due;

    // per-side count of upcoming transfers with no idling
    int calm_left [2];

    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    animation_playhead_advance dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_delta_time (s_delta_time),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_position   (m_position),
        .m_wrapped    (m_wrapped),
        .m_stopped    (m_stopped),
        .m_reversed   (m_reversed),
        .m_updated    (m_updated)
    );

    animation_playhead_advance_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_delta_time   (s_delta_time),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_position     (m_position),
        .m_wrapped      (m_wrapped),
        .m_stopped      (m_stopped),
        .m_reversed     (m_reversed),
        .m_updated      (m_updated),
        .mismatch_count (mismatch_count),
        .reports_due    (reports_due)
    );

    // Idle cycles before the next transfer on one side, drawn at random, with
    // an occasional burst of back-to-back transfers.
    function automatic int idle_draw(input int side);
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm_left[side] = $urandom_range(8, 40);
        end
        return $urandom_range(0, 11);
    endfunction

    // Fill the bits above a register's width with junk; the block must drop them.
    function automatic logic [apa_pkg::CFG_DATA_W-1:0] pad_noise(
        input logic [apa_pkg::CFG_DATA_W-1:0] value, input int width);
        logic [apa_pkg::CFG_DATA_W-1:0] junk;
        junk = $urandom;
        if (width < apa_pkg::CFG_DATA_W) begin
            junk = junk << width;
        end else begin
            junk = '0;
        end
        return junk | value;
    endfunction

    // Mostly full-range ticks, some short frames, a few corner values.
    // gentle keeps every tick short so the playhead creeps toward an end.
    function automatic logic [apa_pkg::DT_W-1:0] draw_delta(input bit gentle);
        int pick;
        if (gentle) begin
            return apa_pkg::DT_W'($urandom_range(0, 16'h03FF));
        end
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            return apa_pkg::DT_W'($urandom_range(0, 16'hFFFF));
        end else if (pick < 8) begin
            return apa_pkg::DT_W'($urandom_range(0, 16'h03FF));
        end
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h1000;  // exactly one second
            default: return 16'h0001;
        endcase
    endfunction

    // One register write; enable drops at the following edge.
    task automatic cfg_write(input logic [apa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [apa_pkg::CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_setup(input logic en, input logic [1:0] mode,
                              input logic [apa_pkg::DUR_W-1:0] track_len,
                              input logic [apa_pkg::RATE_W-1:0] speed);
        cfg_write(apa_pkg::REG_PLAY_ENABLE,    pad_noise({31'd0, en}, 1));
        cfg_write(apa_pkg::REG_END_MODE,       pad_noise({30'd0, mode}, 2));
        cfg_write(apa_pkg::REG_TRACK_DURATION, track_len);
        cfg_write(apa_pkg::REG_BASE_RATE,      pad_noise({16'd0, speed}, apa_pkg::RATE_W));
    endtask

    // Offer one tick after a random gap and hold it until the transfer.
    task automatic send_tick(input logic [apa_pkg::DT_W-1:0] dt);
        int gap;
        gap = idle_draw(SIDE_TX);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_delta_time <= dt;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    // Stop offering ticks and wait for every outstanding result; the block is
    // idle afterwards, so registers may be written.
    task automatic await_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (reports_due != 0) @(posedge aclk);
    endtask

    // Random register set for the loop / ping-pong phases. Tiny tracks make
    // nearly every tick wrap; huge ones exercise the wide divide.
    task automatic random_setup(output logic en);
        logic [apa_pkg::DUR_W-1:0]  track_len;
        logic [apa_pkg::RATE_W-1:0] speed;
        logic [1:0]                 mode;
        case ($urandom_range(0, 9))
            0:       track_len = '0;
            1:       track_len = 32'd1;
            2:       track_len = 32'hFFFF_FFFF;
            3, 4:    track_len = $urandom_range(1, 16);
            5, 6:    track_len = $urandom_range(32'h0000_1000, 32'h0020_0000);
            default: track_len = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0:       speed = 16'h8000;
            1:       speed = 16'h7FFF;
            2:       speed = 16'h0000;
            3, 4: begin
                speed = apa_pkg::RATE_W'($urandom_range(1, 16'h0200));
                if ($urandom_range(0, 1)) begin
                    speed = -speed;
                end
            end
            default: speed = apa_pkg::RATE_W'($urandom);
        endcase
        mode = $urandom_range(0, 1) ? apa_pkg::MODE_LOOP : apa_pkg::MODE_PINGPONG;
        en   = ($urandom_range(0, 7) != 0);
        load_setup(en, mode, track_len, speed);
    endtask

    // Result side: random stall before each transfer, then hold ready until
    // a result goes through.
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = idle_draw(SIDE_RX);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    // Ends the run if neither channel moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[%0t] no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        logic                       en;
        int                         n_ticks;
        logic [apa_pkg::DUR_W-1:0]  track_len;
        logic [apa_pkg::RATE_W-1:0] speed;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // --- directed part ---

        // Out of reset playback is off: ticks report state but move nothing.
        send_tick(16'hFFFF);
        send_tick(16'h0000);
        await_results();

        // Write to an unmapped index must be dropped. Then run loop mode on
        // the reset duration and rate (1.0 / 1.0).
        cfg_write(REG_NONE, '1);
        cfg_write(apa_pkg::REG_END_MODE, pad_noise({30'd0, apa_pkg::MODE_LOOP}, 2));
        cfg_write(apa_pkg::REG_PLAY_ENABLE, pad_noise(32'd1, 1));
        send_tick(16'h0000);
        send_tick(16'h1000);  // lands exactly on the end, no wrap
        send_tick(16'h0001);
        send_tick(16'hFFFF);
        send_tick(16'h7FFF);
        await_results();

        // Most negative rate, loop wraps below zero.
        load_setup(1'b1, apa_pkg::MODE_LOOP, 32'h0003_0000, 16'h8000);
        send_tick(16'hFFFF);
        send_tick(16'h0003);
        send_tick(16'h0100);
        await_results();

        // Fastest forward rate, ping-pong bounces.
        load_setup(1'b1, apa_pkg::MODE_PINGPONG, 32'h0001_0000, 16'h7FFF);
        send_tick(16'hFFFF);
        send_tick(16'h1000);
        send_tick(16'h0800);
        await_results();

        // Longest track, fastest reverse.
        load_setup(1'b1, apa_pkg::MODE_PINGPONG, 32'hFFFF_FFFF, 16'h8000);
        send_tick(16'hFFFF);
        send_tick(16'h0001);
        await_results();

        // Zero duration behaves as one LSB.
        load_setup(1'b1, apa_pkg::MODE_PINGPONG, 32'h0000_0000, 16'h0100);
        send_tick(16'h0010);
        send_tick(16'h1003);
        send_tick(16'h2000);
        await_results();

        // Zero rate: tick is taken but the playhead stays put.
        load_setup(1'b1, apa_pkg::MODE_LOOP, 32'h0000_0001, 16'h0000);
        send_tick(16'hFFFF);
        send_tick(16'h0000);
        await_results();

        // --- random loop / ping-pong phases ---
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_setup(en);
            n_ticks = en ? $urandom_range(80, 120) : 8;
            for (int i = 0; i < n_ticks; i++) begin
                send_tick(draw_delta(1'b0));
            end
            await_results();
        end

        // --- clamp, last because the halt is permanent ---
        // Loop on a short track first so the playhead starts inside it.
        track_len = $urandom_range(32'h0004_0000, 32'h0010_0000);
        speed     = apa_pkg::RATE_W'($urandom_range(16'h0080, 16'h0300));
        if ($urandom_range(0, 1)) begin
            speed = -speed;
        end
        load_setup(1'b1, apa_pkg::MODE_LOOP, track_len, speed);
        for (int i = 0; i < 10; i++) begin
            send_tick(draw_delta(1'b1));
        end
        await_results();

        // Either clamp code; the spare one must act the same.
        cfg_write(apa_pkg::REG_END_MODE,
                  pad_noise({30'd0, $urandom_range(0, 1) ? apa_pkg::MODE_CLAMP : MODE_SPARE},
                            2));
        for (int i = 0; i < 120; i++) begin
            send_tick(draw_delta(1'b1));
        end
        await_results();

        // Rewriting every register must not release the halt.
        load_setup(1'b1, apa_pkg::MODE_LOOP, track_len, speed);
        for (int i = 0; i < 12; i++) begin
            send_tick(draw_delta(1'b0));
        end
        await_results();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/apa_pkg.sv
hw/rtl/apa_divider.sv
hw/rtl/animation_playhead_advance.sv
dv/animation_playhead_advance_checker.sv
dv/animation_playhead_advance_tb.sv
